FILE: design/assert_macros.svh
// Assertion macros used by the gait phase contact detector RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock, idle while reset is held
`define GPCD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every clock, including reset
`define GPCD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/gpcd_pkg.sv
// Types, codes and constants of the gait phase contact detector
`default_nettype none

package gpcd_pkg;

  localparam int ACCEL_BITS = 16;
  localparam int TIME_BITS  = 32;
  localparam int SUM_BITS   = 18;
  localparam int WAIT_BITS  = 10;
  localparam int RATIO_BITS = 8;
  localparam int PROD_BITS  = SUM_BITS + RATIO_BITS;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [2:0] PH_0    = 3'd0;
  localparam logic [2:0] PH_1    = 3'd1;
  localparam logic [2:0] PH_2    = 3'd2;
  localparam logic [2:0] PH_3    = 3'd3;
  localparam logic [2:0] PH_INIT = 3'd4;

  localparam logic [2:0] REG_START_WAIT  = 3'd0;
  localparam logic [2:0] REG_PH0_WAIT    = 3'd1;
  localparam logic [2:0] REG_PH2_WAIT    = 3'd2;
  localparam logic [2:0] REG_BLANK_P1    = 3'd3;
  localparam logic [2:0] REG_BLANK_P2    = 3'd4;
  localparam logic [2:0] REG_BLANK_P3    = 3'd5;
  localparam logic [2:0] REG_BLANK_P0    = 3'd6;
  localparam logic [2:0] REG_RATIO       = 3'd7;

  localparam logic [WAIT_BITS-1:0]  RST_START_WAIT = 10'd110;
  localparam logic [WAIT_BITS-1:0]  RST_PH0_WAIT   = 10'd130;
  localparam logic [WAIT_BITS-1:0]  RST_PH2_WAIT   = 10'd150;
  localparam logic [WAIT_BITS-1:0]  RST_BLANK_P1   = 10'd30;
  localparam logic [WAIT_BITS-1:0]  RST_BLANK_P2   = 10'd90;
  localparam logic [WAIT_BITS-1:0]  RST_BLANK_P3   = 10'd40;
  localparam logic [WAIT_BITS-1:0]  RST_BLANK_P0   = 10'd100;
  localparam logic [WAIT_BITS-1:0]  RST_BLANK      = 10'd120;
  localparam logic [RATIO_BITS-1:0] RST_RATIO      = 8'd51;

  typedef struct packed {
    logic                         func;
    logic [TIME_BITS-1:0]         time_ms;
    logic signed [ACCEL_BITS-1:0] accel_x;
    logic signed [ACCEL_BITS-1:0] accel_y;
    logic signed [ACCEL_BITS-1:0] accel_z;
  } in_t;

  typedef struct packed {
    logic [2:0]          gait_phase;
    logic                sample_used;
    logic                contact_marker;
    logic                contact_confirmed;
    logic [SUM_BITS-1:0] accel_delta;
    logic [SUM_BITS-1:0] peak_out;
  } out_t;

  typedef struct packed {
    logic                 func;
    logic [TIME_BITS-1:0] time_ms;
    logic [SUM_BITS-1:0]  accel_delta;
  } stage_t;

endpackage

`default_nettype wire

FILE: design/gpcd_delta.sv
// L1 norm of the sample-to-sample acceleration difference, with the previous sample
`default_nettype none

module gpcd_delta
  import gpcd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire in_t                 beat_i,
  output logic      [SUM_BITS-1:0] sum_o
);

  logic signed [ACCEL_BITS-1:0] prev_q [3];
  logic signed [ACCEL_BITS-1:0] cur    [3];
  logic        [SUM_BITS-1:0]   mag    [3];

  assign cur[0] = beat_i.accel_x;
  assign cur[1] = beat_i.accel_y;
  assign cur[2] = beat_i.accel_z;

  always_comb begin
    logic signed [ACCEL_BITS:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff = {cur[i][ACCEL_BITS-1], cur[i]} - {prev_q[i][ACCEL_BITS-1], prev_q[i]};
      if (diff[ACCEL_BITS]) begin
        mag[i] = SUM_BITS'(-diff);
      end else begin
        mag[i] = SUM_BITS'(diff);
      end
    end
  end

  assign sum_o = mag[0] + mag[1] + mag[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        prev_q[i] <= '0;
      end
    end else if (load_i) begin
      for (int i = 0; i < 3; i++) begin
        prev_q[i] <= cur[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/gait_phase_contact_detector.sv
// Gait phase sequencer and foot-contact detector, top level
//
//   channel   direction  handshake                         payload
//   in        input      in_valid_i / in_ready_o           in_data_i  (in_t)
//   out       output     out_valid_o / out_ready_i         out_data_o (out_t)
//   config    input      psel/penable/pwrite, pready high  paddr, pwdata, prdata
//
// One beat per cycle sustained while the output is not stalled.
// The input stage registers the beat and its L1 delta against the previous sample,
// the result stage evaluates phase and contact logic into the result register.
// Reset restores register defaults and the initial phase; no clearing pass.
// A stalled output holds its result while one more input beat waits in the input stage.
`default_nettype none

module gait_phase_contact_detector
  import gpcd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_t                      out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready
);

  `include "assert_macros.svh"

  logic [WAIT_BITS-1:0]  start_wait_q, ph0_wait_q, ph2_wait_q;
  logic [WAIT_BITS-1:0]  blank_p1_q, blank_p2_q, blank_p3_q, blank_p0_q;
  logic [RATIO_BITS-1:0] ratio_q;

  logic                 s1_valid_q;
  stage_t               s1_q;
  logic                 out_valid_q;
  out_t                 out_q;
  out_t                 res_d;

  logic [2:0]           phase_q, phase_d;
  logic [TIME_BITS-1:0] phase_start_q, phase_start_d;
  logic                 ticks_started_q, ticks_started_d;
  logic [WAIT_BITS-1:0] blank_q, blank_d;
  logic                 window_passed_q, window_passed_d;
  logic                 latched_q, latched_d;
  logic                 pending_q, pending_d;
  logic [SUM_BITS-1:0]  peak_q, peak_d;

  logic                 in_fire, adv, cfg_wr;
  logic [SUM_BITS-1:0]  sum_in;

  assign adv         = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || adv;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;

  gpcd_delta u_delta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_fire && (in_data_i.func == FUNC_SAMPLE)),
    .beat_i (in_data_i),
    .sum_o  (sum_in)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_wait_q <= RST_START_WAIT;
      ph0_wait_q   <= RST_PH0_WAIT;
      ph2_wait_q   <= RST_PH2_WAIT;
      blank_p1_q   <= RST_BLANK_P1;
      blank_p2_q   <= RST_BLANK_P2;
      blank_p3_q   <= RST_BLANK_P3;
      blank_p0_q   <= RST_BLANK_P0;
      ratio_q      <= RST_RATIO;
    end else if (cfg_wr) begin
      case (paddr[ADDR_BITS-1:2])
        REG_START_WAIT: start_wait_q <= pwdata[WAIT_BITS-1:0];
        REG_PH0_WAIT:   ph0_wait_q   <= pwdata[WAIT_BITS-1:0];
        REG_PH2_WAIT:   ph2_wait_q   <= pwdata[WAIT_BITS-1:0];
        REG_BLANK_P1:   blank_p1_q   <= pwdata[WAIT_BITS-1:0];
        REG_BLANK_P2:   blank_p2_q   <= pwdata[WAIT_BITS-1:0];
        REG_BLANK_P3:   blank_p3_q   <= pwdata[WAIT_BITS-1:0];
        REG_BLANK_P0:   blank_p0_q   <= pwdata[WAIT_BITS-1:0];
        REG_RATIO:      ratio_q      <= pwdata[RATIO_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_BITS-1:2])
      REG_START_WAIT: prdata = DATA_BITS'(start_wait_q);
      REG_PH0_WAIT:   prdata = DATA_BITS'(ph0_wait_q);
      REG_PH2_WAIT:   prdata = DATA_BITS'(ph2_wait_q);
      REG_BLANK_P1:   prdata = DATA_BITS'(blank_p1_q);
      REG_BLANK_P2:   prdata = DATA_BITS'(blank_p2_q);
      REG_BLANK_P3:   prdata = DATA_BITS'(blank_p3_q);
      REG_BLANK_P0:   prdata = DATA_BITS'(blank_p0_q);
      REG_RATIO:      prdata = DATA_BITS'(ratio_q);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    logic [TIME_BITS-1:0] start_ms;
    logic [TIME_BITS-1:0] elapsed;
    logic [SUM_BITS-1:0]  peak_eff;
    logic [PROD_BITS-1:0] prod;
    logic                 below;
    logic                 eval;
    logic                 used;
    logic                 marker;

    phase_d         = phase_q;
    phase_start_d   = phase_start_q;
    ticks_started_d = ticks_started_q;
    blank_d         = blank_q;
    window_passed_d = window_passed_q;
    latched_d       = latched_q;
    pending_d       = pending_q;
    peak_eff        = peak_q;
    used            = 1'b0;
    marker          = 1'b0;
    eval            = window_passed_q;

    start_ms = ticks_started_q ? phase_start_q : s1_q.time_ms;
    elapsed  = s1_q.time_ms - start_ms;

    if (s1_q.func == FUNC_TICK) begin
      ticks_started_d = 1'b1;
      phase_start_d   = start_ms;
      case (phase_q)
        PH_INIT: begin
          if (elapsed >= TIME_BITS'(start_wait_q)) begin
            phase_d = PH_1;  phase_start_d = s1_q.time_ms;
            window_passed_d = 1'b0;  blank_d = blank_p1_q;
          end
        end
        PH_0: begin
          if (elapsed >= TIME_BITS'(ph0_wait_q)) begin
            phase_d = PH_1;  phase_start_d = s1_q.time_ms;
            window_passed_d = 1'b0;  blank_d = blank_p1_q;
          end
        end
        PH_1: begin
          if (latched_q) begin
            latched_d = 1'b0;
            phase_d = PH_2;  phase_start_d = s1_q.time_ms;
            window_passed_d = 1'b0;  blank_d = blank_p2_q;
          end
        end
        PH_2: begin
          if (elapsed >= TIME_BITS'(ph2_wait_q)) begin
            phase_d = PH_3;  phase_start_d = s1_q.time_ms;
            window_passed_d = 1'b0;  blank_d = blank_p3_q;
          end
        end
        PH_3: begin
          if (latched_q) begin
            latched_d = 1'b0;
            phase_d = PH_0;  phase_start_d = s1_q.time_ms;
            window_passed_d = 1'b0;  blank_d = blank_p0_q;
          end
        end
        default: begin
        end
      endcase
    end else if (!window_passed_q && ticks_started_q &&
                 elapsed >= TIME_BITS'(blank_q)) begin
      eval            = 1'b1;
      window_passed_d = 1'b1;
      peak_eff        = s1_q.accel_delta;
    end

    prod  = PROD_BITS'(peak_eff) * PROD_BITS'(ratio_q);
    below = {s1_q.accel_delta, {RATIO_BITS{1'b0}}} < prod;

    if (s1_q.func == FUNC_SAMPLE && eval) begin
      used = 1'b1;
      if (s1_q.accel_delta > peak_eff) begin
        peak_eff  = s1_q.accel_delta;
        pending_d = 1'b0;
      end else if ((phase_q == PH_1 || phase_q == PH_3) && !pending_q && below) begin
        pending_d = 1'b1;
        marker    = 1'b1;
      end else if (pending_q && below) begin
        pending_d = 1'b0;
        marker    = 1'b1;
        latched_d = 1'b1;
      end else begin
        pending_d = 1'b0;
      end
    end
    peak_d = peak_eff;

    res_d.gait_phase        = phase_d;
    res_d.sample_used       = used;
    res_d.contact_marker    = marker;
    res_d.contact_confirmed = latched_d;
    res_d.accel_delta       = (s1_q.func == FUNC_SAMPLE) ? s1_q.accel_delta : '0;
    res_d.peak_out          = peak_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.func        <= in_data_i.func;
      s1_q.time_ms     <= in_data_i.time_ms;
      s1_q.accel_delta <= sum_in;
    end
    if (adv) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_INIT;
      phase_start_q   <= '0;
      ticks_started_q <= 1'b0;
      blank_q         <= RST_BLANK;
      window_passed_q <= 1'b0;
      latched_q       <= 1'b0;
      pending_q       <= 1'b0;
      peak_q          <= '0;
    end else if (adv) begin
      phase_q         <= phase_d;
      phase_start_q   <= phase_start_d;
      ticks_started_q <= ticks_started_d;
      blank_q         <= blank_d;
      window_passed_q <= window_passed_d;
      latched_q       <= latched_d;
      pending_q       <= pending_d;
      peak_q          <= peak_d;
    end
  end

  `GPCD_ASSERT(a_empty_stage_ready, !s1_valid_q |-> in_ready_o, "input stage empty but not ready")
  `GPCD_ASSERT(a_used_opens_window, adv && res_d.sample_used |=> window_passed_q,
               "evaluated sample left the blanking window closed")
  `GPCD_ASSERT(a_peak_covers_sum, adv && res_d.sample_used |=> peak_q >= out_q.accel_delta,
               "tracked peak below an evaluated delta")
  `GPCD_ASSERT(a_swing_clears_latch,
               adv && s1_q.func == FUNC_TICK && phase_q == PH_1 && latched_q
               |=> phase_q == PH_2 && !latched_q,
               "confirmed contact did not advance swing phase")

endmodule

`default_nettype wire

FILE: tb/sv/gait_phase_contact_detector_test.sv
// Self-checking testbench for the gait phase contact detector: scoreboard, stimulus, checks
import gpcd_pkg::*;

class gait_scoreboard;
  bit [WAIT_BITS-1:0]  start_wait, ph0_wait, ph2_wait;
  bit [WAIT_BITS-1:0]  blank_p1, blank_p2, blank_p3, blank_p0;
  bit [RATIO_BITS-1:0] ratio;
  bit [2:0]            phase;
  bit [TIME_BITS-1:0]  phase_t0;
  bit [WAIT_BITS-1:0]  blank_ms;
  bit                  ticking, blank_done, latched, half_contact;
  bit signed [ACCEL_BITS-1:0] last_acc [3];
  bit [SUM_BITS-1:0]   peak;
  out_t                gait_result_q [$];
  int                  errors;

  function new();
    start_wait   = RST_START_WAIT;
    ph0_wait     = RST_PH0_WAIT;
    ph2_wait     = RST_PH2_WAIT;
    blank_p1     = RST_BLANK_P1;
    blank_p2     = RST_BLANK_P2;
    blank_p3     = RST_BLANK_P3;
    blank_p0     = RST_BLANK_P0;
    ratio        = RST_RATIO;
    phase        = PH_INIT;
    phase_t0     = '0;
    blank_ms     = RST_BLANK;
    ticking      = 1'b0;
    blank_done   = 1'b0;
    latched      = 1'b0;
    half_contact = 1'b0;
    peak         = '0;
    errors       = 0;
    for (int i = 0; i < 3; i++) last_acc[i] = '0;
  endfunction

  function void set_reg(bit [2:0] idx, bit [DATA_BITS-1:0] val);
    case (idx)
      REG_START_WAIT: start_wait = val[WAIT_BITS-1:0];
      REG_PH0_WAIT:   ph0_wait   = val[WAIT_BITS-1:0];
      REG_PH2_WAIT:   ph2_wait   = val[WAIT_BITS-1:0];
      REG_BLANK_P1:   blank_p1   = val[WAIT_BITS-1:0];
      REG_BLANK_P2:   blank_p2   = val[WAIT_BITS-1:0];
      REG_BLANK_P3:   blank_p3   = val[WAIT_BITS-1:0];
      REG_BLANK_P0:   blank_p0   = val[WAIT_BITS-1:0];
      REG_RATIO:      ratio      = val[RATIO_BITS-1:0];
      default: ;
    endcase
  endfunction

  function void enter_phase(bit [2:0] p, bit [TIME_BITS-1:0] now, bit [WAIT_BITS-1:0] blank);
    phase      = p;
    phase_t0   = now;
    blank_done = 1'b0;
    blank_ms   = blank;
  endfunction

  function void note_gait_beat(in_t b);
    out_t r;
    bit [TIME_BITS-1:0] elapsed;
    int acc, d;
    bit used, marker, eval, below;
    bit signed [ACCEL_BITS-1:0] cur [3];
    acc    = 0;
    used   = 1'b0;
    marker = 1'b0;
    if (b.func == FUNC_TICK) begin
      if (!ticking) begin
        phase_t0 = b.time_ms;
        ticking  = 1'b1;
      end
      elapsed = b.time_ms - phase_t0;
      if (phase == PH_INIT && elapsed >= start_wait) begin
        enter_phase(PH_1, b.time_ms, blank_p1);
      end else if (phase == PH_0 && elapsed >= ph0_wait) begin
        enter_phase(PH_1, b.time_ms, blank_p1);
      end else if (phase == PH_1 && latched) begin
        latched = 1'b0;
        enter_phase(PH_2, b.time_ms, blank_p2);
      end else if (phase == PH_2 && elapsed >= ph2_wait) begin
        enter_phase(PH_3, b.time_ms, blank_p3);
      end else if (phase == PH_3 && latched) begin
        latched = 1'b0;
        enter_phase(PH_0, b.time_ms, blank_p0);
      end
    end else begin
      cur[0] = b.accel_x;
      cur[1] = b.accel_y;
      cur[2] = b.accel_z;
      for (int i = 0; i < 3; i++) begin
        d = int'(cur[i]) - int'(last_acc[i]);
        acc += (d < 0) ? -d : d;
        last_acc[i] = cur[i];
      end
      eval = 1'b1;
      if (!blank_done) begin
        elapsed = b.time_ms - phase_t0;
        if (!ticking || elapsed < blank_ms) begin
          eval = 1'b0;
        end else begin
          blank_done = 1'b1;
          peak       = SUM_BITS'(acc);
        end
      end
      if (eval) begin
        below = (longint'(acc) * 256) < (longint'(peak) * longint'(ratio));
        used  = 1'b1;
        if (acc > int'(peak)) begin
          peak         = SUM_BITS'(acc);
          half_contact = 1'b0;
        end else if ((phase == PH_1 || phase == PH_3) && !half_contact && below) begin
          half_contact = 1'b1;
          marker       = 1'b1;
        end else if (half_contact && below) begin
          half_contact = 1'b0;
          marker       = 1'b1;
          latched      = 1'b1;
        end else begin
          half_contact = 1'b0;
        end
      end
    end
    r.gait_phase        = phase;
    r.sample_used       = used;
    r.contact_marker    = marker;
    r.contact_confirmed = latched;
    r.accel_delta       = SUM_BITS'(acc);
    r.peak_out          = peak;
    gait_result_q.push_back(r);
  endfunction

  function void check_gait_result(out_t got);
    out_t e;
    if (gait_result_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result beat with nothing expected: %h", got);
    end else begin
      e = gait_result_q.pop_front();
      if (got.gait_phase !== e.gait_phase || got.sample_used !== e.sample_used ||
          got.contact_marker !== e.contact_marker ||
          got.contact_confirmed !== e.contact_confirmed ||
          got.accel_delta !== e.accel_delta || got.peak_out !== e.peak_out) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp/act: phase %0d/%0d used %0b/%0b marker %0b/%0b",
                   e.gait_phase, got.gait_phase, e.sample_used, got.sample_used,
                   e.contact_marker, got.contact_marker);
          $display("  confirmed %0b/%0b delta %0d/%0d peak %0d/%0d",
                   e.contact_confirmed, got.contact_confirmed, e.accel_delta, got.accel_delta,
                   e.peak_out, got.peak_out);
        end
      end
    end
  endfunction

  function int pending();
    return gait_result_q.size();
  endfunction
endclass

module gait_phase_contact_detector_test;
  localparam int WATCHDOG_CYCLES = 2000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  in_t                  in_data_i   = '0;
  logic                 out_ready_i = 1'b0;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [ADDR_BITS-1:0] paddr       = '0;
  logic [DATA_BITS-1:0] pwdata      = '0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  out_t                 out_data_o;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  gait_scoreboard sb;
  bit  idle_on;
  int  gap_pct, stall_pct, stall_left, quiet_cycles;
  bit  [TIME_BITS-1:0] now_ms;
  bit  signed [ACCEL_BITS-1:0] walk_acc [3];

  always #6 clk_i = ~clk_i;

  gait_phase_contact_detector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always @(negedge clk_i) begin
    if (!idle_on) stall_left = 0;
    else if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 18);
    out_ready_i <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_gait_beat(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_gait_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_beat(in_t b);
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_item(bit f, bit [TIME_BITS-1:0] t, int x, int y, int z);
    in_t b;
    b.func    = f;
    b.time_ms = t;
    b.accel_x = ACCEL_BITS'(x);
    b.accel_y = ACCEL_BITS'(y);
    b.accel_z = ACCEL_BITS'(z);
    send_beat(b);
  endtask

  task automatic write_reg(bit [2:0] idx, bit [DATA_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic program_regs(int lo, int hi, int rlo, int rhi);
    for (int i = REG_START_WAIT; i <= REG_BLANK_P0; i++) write_reg(3'(i), $urandom_range(hi, lo));
    write_reg(REG_RATIO, $urandom_range(rhi, rlo));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold off with input valid low until every result beat is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_walk(int count, int step_max);
    in_t b;
    repeat (count) begin
      if ($urandom_range(0, 99) < 10) begin
        b.func    = 1'($urandom_range(0, 1));
        b.time_ms = $urandom;
        b.accel_x = ACCEL_BITS'($urandom);
        b.accel_y = ACCEL_BITS'($urandom);
        b.accel_z = ACCEL_BITS'($urandom);
        now_ms    = b.time_ms;
      end else begin
        now_ms    = now_ms + $urandom_range(0, step_max);
        b.time_ms = now_ms;
        if ($urandom_range(0, 99) < 30) begin
          b.func    = FUNC_TICK;
          b.accel_x = ACCEL_BITS'($urandom);
          b.accel_y = ACCEL_BITS'($urandom);
          b.accel_z = ACCEL_BITS'($urandom);
        end else begin
          b.func = FUNC_SAMPLE;
          for (int i = 0; i < 3; i++) begin
            if ($urandom_range(0, 99) < 12) walk_acc[i] = ACCEL_BITS'($urandom);
            else walk_acc[i] = ACCEL_BITS'(int'(walk_acc[i]) + int'($urandom_range(0, 6)) - 3);
          end
          b.accel_x = walk_acc[0];
          b.accel_y = walk_acc[1];
          b.accel_z = walk_acc[2];
        end
      end
      send_beat(b);
    end
  endtask

  initial begin
    bit [TIME_BITS-1:0] t;
    sb         = new();
    idle_on    = 1'b1;
    gap_pct    = 20;
    stall_pct  = 10;
    stall_left = 0;
    now_ms     = '0;
    for (int i = 0; i < 3; i++) walk_acc[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(FUNC_SAMPLE, 5, 32767, 32767, 32767);
    send_item(FUNC_SAMPLE, 6, -32768, -32768, -32768);
    t = 32'hFFFF_FFC0;
    send_item(FUNC_TICK, t, 0, 0, 0);
    send_item(FUNC_SAMPLE, t + 1, -32768, -32768, -32768);
    send_item(FUNC_TICK, t + 50, 0, 0, 0);
    t = 32'h0000_0030;
    send_item(FUNC_TICK, t, 0, 0, 0);
    send_item(FUNC_SAMPLE, t + 1, -32768, -32768, -32768);
    send_item(FUNC_SAMPLE, t + 30, 1000, 0, 0);
    send_item(FUNC_SAMPLE, t + 32, 1000, 0, 0);
    send_item(FUNC_SAMPLE, t + 33, 1001, 0, 0);
    t = t + 34;
    send_item(FUNC_TICK, t, 0, 0, 0);
    send_item(FUNC_SAMPLE, t + 10, 1001, 0, 0);
    send_item(FUNC_TICK, t + 149, 0, 0, 0);
    t = t + 150;
    send_item(FUNC_TICK, t, 0, 0, 0);
    send_item(FUNC_SAMPLE, t + 40, -5000, 200, 300);
    send_item(FUNC_SAMPLE, t + 41, -5000, 200, 300);
    send_item(FUNC_SAMPLE, t + 42, 20000, -20000, 300);
    send_item(FUNC_SAMPLE, t + 43, 20000, -20000, 300);
    send_item(FUNC_TICK, t + 44, 0, 0, 0);
    send_item(FUNC_SAMPLE, t + 45, 20000, -20000, 301);
    t = t + 46;
    send_item(FUNC_TICK, t, 0, 0, 0);
    send_item(FUNC_SAMPLE, t + 100, 20010, -20000, 301);
    send_item(FUNC_SAMPLE, t + 101, 20010, -20000, 301);
    send_item(FUNC_TICK, t + 130, -1, -1, -1);
    send_item(FUNC_SAMPLE, 32'hFFFF_FFFF, 0, 0, 0);
    now_ms = t + 131;
    drain();

    program_regs(0, 0, 255, 255);
    gap_pct   = 25;
    stall_pct = 25;
    run_walk(80, 20);
    drain();

    program_regs(1023, 1023, 0, 0);
    gap_pct   = 5;
    stall_pct = 30;
    run_walk(100, 60);
    drain();

    program_regs(0, 60, 20, 120);
    gap_pct   = 40;
    stall_pct = 5;
    run_walk(100, 15);
    drain();

    program_regs(0, 1023, 0, 255);
    gap_pct   = 10;
    stall_pct = 10;
    run_walk(100, 80);
    drain();

    program_regs(20, 150, 40, 80);
    idle_on = 1'b0;
    run_walk(100, 25);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+design
design/gpcd_pkg.sv
design/gpcd_delta.sv
design/gait_phase_contact_detector.sv
tb/sv/gait_phase_contact_detector_test.sv
